/* rtl/sbe_pkg.sv */
// Shared types and constants for the stego level bit extractor.
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

   // Field widths
   localparam int LEVEL_W     = 16;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 32;
   localparam int COUNT_W     = 33;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Bytes of big-endian length header
   localparam logic [COUNT_W-1:0] HEADER_BYTES = 33'd4;

   // Byte queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKIP_LEVEL      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTRACT_ENABLE  = 2'd2;

   // Register reset values
   localparam logic signed [LEVEL_W-1:0] THRESHOLD_RESET = 16'sd5;
   localparam logic signed [LEVEL_W-1:0] SKIP_RESET      = 16'sd127;

   // Result byte classes
   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_BEYOND  = 2'd2
   } byte_kind_type;

   // Configuration seen by the front end
   typedef struct packed {
      logic signed [LEVEL_W-1:0] level_threshold;
      logic signed [LEVEL_W-1:0] skip_level;
      logic                      extract_enable;
   } cfg_type;

   // Queue write side
   typedef struct packed {
      logic              push;
      logic [BYTE_W-1:0] data;
   } queue_wr_type;

   // Queue read side status
   typedef struct packed {
      logic              empty;
      logic              full;
      logic [BYTE_W-1:0] head;
   } queue_rd_type;

endpackage

`default_nettype wire

/* rtl/sbe_front.sv */
// Front end: qualifies levels and assembles hidden bits into bytes.
`timescale 1ns / 1ps
`default_nettype none

module sbe_front
   import sbe_pkg::*;
#(
   parameter int BITS_PER_LEVEL = 2
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cfg_type                   cfg,
   input  wire logic                      take,
   input  wire logic signed [LEVEL_W-1:0] level,
   output queue_wr_type                   wr
);

   localparam int SUM_W = 4;

   logic [BYTE_W-1:0]   bit_shift_ff, bit_shift_in;
   logic [2:0]          bit_count_ff, bit_count_in;
   logic                qualify;
   logic [2*BYTE_W-1:0] merged;
   logic [SUM_W-1:0]    total;
   logic [2:0]          rem_bits;
   logic [BYTE_W-1:0]   rem_mask;

   // Level carries bits only when enabled, above threshold and not the skip value
   assign qualify = cfg.extract_enable && (level > cfg.level_threshold) &&
                    (level != cfg.skip_level);

   // Append the new bits below those already collected
   assign merged = ({8'd0, bit_shift_ff} << BITS_PER_LEVEL) |
                   (2*BYTE_W)'(level[BITS_PER_LEVEL-1:0]);
   assign total    = {1'b0, bit_count_ff} + SUM_W'(BITS_PER_LEVEL);
   assign rem_bits = total[2:0];
   assign rem_mask = (8'd1 << rem_bits) - 8'd1;

   // Split off a finished byte when the bit total reaches eight
   always_comb begin
      bit_shift_in = bit_shift_ff;
      bit_count_in = bit_count_ff;
      wr.push      = 1'b0;
      wr.data      = BYTE_W'(merged >> rem_bits);
      if (take && qualify) begin
         if (total[3]) begin
            wr.push      = 1'b1;
            bit_shift_in = merged[BYTE_W-1:0] & rem_mask;
            bit_count_in = rem_bits;
         end else begin
            bit_shift_in = merged[BYTE_W-1:0];
            bit_count_in = total[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_shift_ff <= '0;
         bit_count_ff <= '0;
      end else begin
         bit_shift_ff <= bit_shift_in;
         bit_count_ff <= bit_count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/sbe_queue.sv */
// Short byte queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module sbe_queue
   import sbe_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire queue_wr_type wr,
   input  wire logic         pop,
   output queue_rd_type      rd
);

   logic [BYTE_W-1:0]      mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   // Status and head of queue
   assign rd.empty = (count_ff == '0);
   assign rd.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign rd.head  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!wr.push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (wr.push) begin
         mem_ff[wr_ptr_ff] <= wr.data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count exceeds depth");

   assert property (@(posedge clock) disable iff (reset)
      wr.push |-> !rd.full)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> !rd.empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/sbe_back.sv */
// Back end: counts bytes, builds the message length and classifies each byte.
`timescale 1ns / 1ps
`default_nettype none

module sbe_back
   import sbe_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire queue_rd_type rd,
   output logic              pop,
   input  wire logic         rsp_stall,
   output logic              rsp_valid,
   output logic [BYTE_W-1:0] rsp_data_byte,
   output byte_kind_type     rsp_byte_kind,
   output logic              rsp_last_payload,
   output logic [LEN_W-1:0]  rsp_length_so_far
);

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [LEN_W-1:0]   message_len_ff, message_len_in;
   logic [COUNT_W-1:0] msg_end_ff, msg_end_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  data_ff;
   byte_kind_type      kind_ff, kind_in;
   logic               last_ff, last_in;
   logic [LEN_W-1:0]   len_out_ff;

   // Take the next byte when the output register is free or draining
   assign pop = !rd.empty && (!rsp_valid_ff || !rsp_stall);

   // Saturating byte count, header assembly and classification
   always_comb begin
      byte_count_in  = byte_count_ff;
      message_len_in = message_len_ff;
      msg_end_in     = msg_end_ff;
      kind_in        = KIND_BEYOND;
      last_in        = 1'b0;
      if (pop) begin
         if (byte_count_ff != '1) begin
            byte_count_in = byte_count_ff + 1'b1;
         end
         if (byte_count_in <= HEADER_BYTES) begin
            kind_in = KIND_HEADER;
            case (byte_count_in[2:0])
               3'd1:    message_len_in[31:24] = message_len_ff[31:24] | rd.head;
               3'd2:    message_len_in[23:16] = message_len_ff[23:16] | rd.head;
               3'd3:    message_len_in[15:8]  = message_len_ff[15:8]  | rd.head;
               3'd4:    message_len_in[7:0]   = message_len_ff[7:0]   | rd.head;
               default: message_len_in = message_len_ff;
            endcase
            msg_end_in = {1'b0, message_len_in} + HEADER_BYTES;
         end else if (byte_count_in <= msg_end_ff) begin
            kind_in = KIND_PAYLOAD;
            last_in = (byte_count_in == msg_end_ff);
         end
      end
   end

   // Output register holds while stalled
   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         message_len_ff <= '0;
         msg_end_ff     <= HEADER_BYTES;
         rsp_valid_ff   <= 1'b0;
      end else begin
         byte_count_ff  <= byte_count_in;
         message_len_ff <= message_len_in;
         msg_end_ff     <= msg_end_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff    <= rd.head;
         kind_ff    <= kind_in;
         last_ff    <= last_in;
         len_out_ff <= message_len_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_byte_kind     = kind_ff;
   assign rsp_last_payload  = last_ff;
   assign rsp_length_so_far = len_out_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |-> (kind_ff == KIND_PAYLOAD))
      else $error("last flag on a non-payload byte");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_HEADER) |-> (byte_count_ff <= HEADER_BYTES))
      else $error("header byte reported after header end");

   assert property (@(posedge clock) disable iff (reset)
      ##1 (byte_count_ff >= $past(byte_count_ff)))
      else $error("byte count went backward");

endmodule

`default_nettype wire

/* rtl/stego_level_bit_extractor.sv */
// Top level of the stego level bit extractor.
// Usage:
//   req_ channel carries one signed 16-bit coefficient level per transaction.
//   A level above level_threshold, unequal to skip_level, with extract_enable
//   set, gives its low BITS_PER_LEVEL bits (MSB first) to a byte assembler.
//   rsp_ channel carries one transaction per completed byte: the byte, its
//   kind (length header, payload, beyond the end), a last-payload flag and
//   the message length gathered so far. The first four bytes are the
//   big-endian length.
//   csr_ port writes threshold, skip level and enable; write only when idle.
// Timing:
//   One level per cycle unless req_stall is high. A byte completed by a level
//   is written to the queue, then popped into the output register (rsp_valid).
//   A four-byte queue separates the bit assembler from the byte classifier.
//   When rsp_stall holds the output register, the queue fills and req_stall
//   rises once it holds four bytes.
// Reset: synchronous; clears assembler, counters and length, and loads the
//   register defaults (threshold 5, skip level 127, enable 1).
`timescale 1ns / 1ps
`default_nettype none

module stego_level_bit_extractor
   import sbe_pkg::*;
#(
   parameter int BITS_PER_LEVEL = 2
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [LEVEL_W-1:0] req_level,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [BYTE_W-1:0]              rsp_data_byte,
   output logic [1:0]                     rsp_byte_kind,
   output logic                           rsp_last_payload,
   output logic [LEN_W-1:0]               rsp_length_so_far,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   queue_wr_type  wr;
   queue_rd_type  rd;
   logic          pop;
   logic          take;
   byte_kind_type kind;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LEVEL_THRESHOLD: cfg_in.level_threshold = $signed(csr_wdata);
            CSR_SKIP_LEVEL:      cfg_in.skip_level      = $signed(csr_wdata);
            CSR_EXTRACT_ENABLE:  cfg_in.extract_enable  = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_threshold <= THRESHOLD_RESET;
         cfg_ff.skip_level      <= SKIP_RESET;
         cfg_ff.extract_enable  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input transaction accepted while the queue has room
   assign req_stall = rd.full;
   assign take      = req_valid && !req_stall;

   sbe_front #(
      .BITS_PER_LEVEL(BITS_PER_LEVEL)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .take  (take),
      .level (req_level),
      .wr    (wr)
   );

   sbe_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .pop   (pop),
      .rd    (rd)
   );

   sbe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .rd                (rd),
      .pop               (pop),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_kind     (kind),
      .rsp_last_payload  (rsp_last_payload),
      .rsp_length_so_far (rsp_length_so_far)
   );

   assign rsp_byte_kind = kind;

endmodule

`default_nettype wire
